// ===== hw/rtl/prdw_pkg.sv =====
// Shared definitions for the Pollard rho walk step unit: word width, register
// indices, reset values, class codes and the request/response bundles of the
// serial arithmetic units. No dependencies.
package prdw_pkg;

    // Word width of every element, exponent and modulus.
    localparam int WORD_BITS = 64;
    // The remainder unit takes one extra dividend bit for doubled or incremented exponents.
    localparam int DVD_BITS  = WORD_BITS + 1;
    localparam int REM_CNT_W = $clog2(DVD_BITS + 1);
    localparam int MUL_CNT_W = $clog2(WORD_BITS + 1);
    // Three words per stream transaction, padded to whole bytes.
    localparam int TDATA_W   = ((3 * WORD_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_W = 3;

    typedef logic [WORD_BITS-1:0] word_t;

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_MOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_MOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_DIV  = 3'd4;

    // Register values after reset.
    localparam word_t RST_GROUP_MOD = word_t'(3);
    localparam word_t RST_EXP_MOD   = word_t'(1);
    localparam word_t RST_GENERATOR = word_t'(1);
    localparam word_t RST_TARGET    = word_t'(1);
    localparam word_t RST_DIST_DIV  = word_t'(12'hfff);

    // Request kinds carried in tuser.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // Walk classes, selected by x mod 3.
    localparam word_t      CLASS_COUNT = word_t'(3);
    localparam logic [1:0] CLS_SQUARE  = 2'd0;
    localparam logic [1:0] CLS_GEN     = 2'd1;
    localparam logic [1:0] CLS_TGT     = 2'd2;

    // Request to the serial remainder unit.
    typedef struct packed {
        logic                start;
        logic [DVD_BITS-1:0] dividend;
        word_t               divisor;
    } rem_req_t;

    // Request to the serial modular multiplier.
    typedef struct packed {
        logic  start;
        word_t mcand;
        word_t mplier;
        word_t modulus;
    } mul_req_t;

    // Completion pulse and result of either unit.
    typedef struct packed {
        logic  done;
        word_t value;
    } unit_rsp_t;

endpackage

// ===== hw/rtl/pollard_rho_dlog_walk_step_unit.sv =====
// Pollard rho walk step unit: holds (x, a, b) and performs load or three-class walk steps.
// Each part runs on the shared bit-serial remainder unit or the two-phase serial multiplier.
// One transaction at a time; a finished result waits in the output register meanwhile.
// Reset (aresetn low, synchronous) clears the walk state to zero and the registers to defaults.
module pollard_rho_dlog_walk_step_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [prdw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prdw_pkg::WORD_BITS-1:0]    cfg_data,
    // Request stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [prdw_pkg::TDATA_W-1:0]      s_tdata,   // start_x, start_a, start_b
    input  logic                              s_tuser,   // req_type
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [prdw_pkg::TDATA_W-1:0]      m_tdata,   // walk_x, walk_a, walk_b
    output logic                              m_tuser    // distinguished
);
    import prdw_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CLASS = 8'b0000_0010,
        ST_XRED  = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_EXPA  = 8'b0001_0000,
        ST_EXPB  = 8'b0010_0000,
        ST_DIST  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic                run_reg, run_next;

    word_t               grp_mod_reg, exp_mod_reg, gen_reg, tgt_reg, dist_div_reg;
    word_t               cur_x_reg, cur_a_reg, cur_b_reg;
    logic [DVD_BITS-1:0] a_src_reg, b_src_reg;
    logic                do_a_reg, do_b_reg;
    logic [1:0]          cls_reg;
    word_t               mul_x_reg;
    logic                dist_reg;
    word_t               out_x_reg, out_a_reg, out_b_reg;
    logic                out_dist_reg;
    logic                m_tvalid_reg;

    rem_req_t            rem_req;
    mul_req_t            mul_req;
    unit_rsp_t           rem_rsp;
    unit_rsp_t           mul_rsp;

    logic                accept;
    logic                cls_wr, xred_wr, x_wr, a_wr, b_wr, dist_wr, out_load;
    word_t               xred_val, exp_a_val, exp_b_val;
    logic                dist_val;

    prdw_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rem_req),
        .rsp     (rem_rsp)
    );

    prdw_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Values written back: unit result when a unit ran, otherwise the direct (wrapping) value.
    assign xred_val  = run_reg ? rem_rsp.value : cur_x_reg;
    assign exp_a_val = run_reg ? rem_rsp.value : a_src_reg[WORD_BITS-1:0];
    assign exp_b_val = run_reg ? rem_rsp.value : b_src_reg[WORD_BITS-1:0];
    assign dist_val  = run_reg ? (rem_rsp.value == '0) : (cur_x_reg == '0);

    // Sequencer: each state starts its unit once and waits for done; a zero divisor or an unused exponent skips it.
    always_comb begin
        state_next       = state_reg;
        run_next         = run_reg;
        rem_req.start    = 1'b0;
        rem_req.dividend = {1'b0, cur_x_reg};
        rem_req.divisor  = CLASS_COUNT;
        mul_req.start    = 1'b0;
        mul_req.mcand    = mul_x_reg;
        mul_req.modulus  = grp_mod_reg;
        cls_wr           = 1'b0;
        xred_wr          = 1'b0;
        x_wr             = 1'b0;
        a_wr             = 1'b0;
        b_wr             = 1'b0;
        dist_wr          = 1'b0;
        out_load         = 1'b0;

        case (cls_reg)
            CLS_SQUARE: mul_req.mplier = cur_x_reg;
            CLS_GEN:    mul_req.mplier = gen_reg;
            default:    mul_req.mplier = tgt_reg;
        endcase

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == REQ_LOAD) ? ST_EXPA : ST_CLASS;
                end
            end
            ST_CLASS: begin
                if (!run_reg) begin
                    rem_req.start = 1'b1;
                    run_next      = 1'b1;
                end else if (rem_rsp.done) begin
                    run_next   = 1'b0;
                    cls_wr     = 1'b1;
                    state_next = ST_XRED;
                end
            end
            ST_XRED: begin
                rem_req.divisor = grp_mod_reg;
                if (!run_reg) begin
                    if (grp_mod_reg == '0) begin
                        xred_wr    = 1'b1;
                        state_next = ST_MUL;
                    end else begin
                        rem_req.start = 1'b1;
                        run_next      = 1'b1;
                    end
                end else if (rem_rsp.done) begin
                    run_next   = 1'b0;
                    xred_wr    = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (!run_reg) begin
                    mul_req.start = 1'b1;
                    run_next      = 1'b1;
                end else if (mul_rsp.done) begin
                    run_next   = 1'b0;
                    x_wr       = 1'b1;
                    state_next = ST_EXPA;
                end
            end
            ST_EXPA: begin
                rem_req.dividend = a_src_reg;
                rem_req.divisor  = exp_mod_reg;
                if (!do_a_reg) begin
                    state_next = ST_EXPB;
                end else if (!run_reg) begin
                    if (exp_mod_reg == '0) begin
                        a_wr       = 1'b1;
                        state_next = ST_EXPB;
                    end else begin
                        rem_req.start = 1'b1;
                        run_next      = 1'b1;
                    end
                end else if (rem_rsp.done) begin
                    run_next   = 1'b0;
                    a_wr       = 1'b1;
                    state_next = ST_EXPB;
                end
            end
            ST_EXPB: begin
                rem_req.dividend = b_src_reg;
                rem_req.divisor  = exp_mod_reg;
                if (!do_b_reg) begin
                    state_next = ST_DIST;
                end else if (!run_reg) begin
                    if (exp_mod_reg == '0) begin
                        b_wr       = 1'b1;
                        state_next = ST_DIST;
                    end else begin
                        rem_req.start = 1'b1;
                        run_next      = 1'b1;
                    end
                end else if (rem_rsp.done) begin
                    run_next   = 1'b0;
                    b_wr       = 1'b1;
                    state_next = ST_DIST;
                end
            end
            ST_DIST: begin
                rem_req.divisor = dist_div_reg;
                if (!run_reg) begin
                    if (dist_div_reg == '0) begin
                        dist_wr    = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        rem_req.start = 1'b1;
                        run_next      = 1'b1;
                    end
                end else if (rem_rsp.done) begin
                    run_next   = 1'b0;
                    dist_wr    = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                run_next   = 1'b0;
            end
        endcase
    end

    // State, handshake and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            run_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            grp_mod_reg  <= RST_GROUP_MOD;
            exp_mod_reg  <= RST_EXP_MOD;
            gen_reg      <= RST_GENERATOR;
            tgt_reg      <= RST_TARGET;
            dist_div_reg <= RST_DIST_DIV;
        end else begin
            state_reg <= state_next;
            run_reg   <= run_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_GROUP_MOD: grp_mod_reg  <= cfg_data;
                    CFG_EXP_MOD:   exp_mod_reg  <= cfg_data;
                    CFG_GENERATOR: gen_reg      <= cfg_data;
                    CFG_TARGET:    tgt_reg      <= cfg_data;
                    CFG_DIST_DIV:  dist_div_reg <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    // Walk state: cleared by reset, loaded or updated as the sequencer completes each part.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg <= '0;
            cur_a_reg <= '0;
            cur_b_reg <= '0;
        end else begin
            if (accept && (s_tuser == REQ_LOAD)) begin
                cur_x_reg <= s_tdata[WORD_BITS-1:0];
            end else if (x_wr) begin
                cur_x_reg <= mul_rsp.value;
            end
            if (a_wr) begin
                cur_a_reg <= exp_a_val;
            end
            if (b_wr) begin
                cur_b_reg <= exp_b_val;
            end
        end
    end

    // Working operands of the current transaction.
    always_ff @(posedge aclk) begin
        if (accept && (s_tuser == REQ_LOAD)) begin
            a_src_reg <= {1'b0, s_tdata[2*WORD_BITS-1:WORD_BITS]};
            b_src_reg <= {1'b0, s_tdata[3*WORD_BITS-1:2*WORD_BITS]};
            do_a_reg  <= 1'b1;
            do_b_reg  <= 1'b1;
        end else if (cls_wr) begin
            cls_reg <= rem_rsp.value[1:0];
            case (rem_rsp.value[1:0])
                CLS_SQUARE: begin
                    a_src_reg <= {cur_a_reg, 1'b0};
                    b_src_reg <= {cur_b_reg, 1'b0};
                    do_a_reg  <= 1'b1;
                    do_b_reg  <= 1'b1;
                end
                CLS_GEN: begin
                    a_src_reg <= {1'b0, cur_a_reg} + DVD_BITS'(1);
                    do_a_reg  <= 1'b1;
                    do_b_reg  <= 1'b0;
                end
                default: begin
                    b_src_reg <= {1'b0, cur_b_reg} + DVD_BITS'(1);
                    do_a_reg  <= 1'b0;
                    do_b_reg  <= 1'b1;
                end
            endcase
        end
        if (xred_wr) begin
            mul_x_reg <= xred_val;
        end
        if (dist_wr) begin
            dist_reg <= dist_val;
        end
    end

    // Output register; the next transaction may start while a result waits here.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_x_reg    <= cur_x_reg;
            out_a_reg    <= cur_a_reg;
            out_b_reg    <= cur_b_reg;
            out_dist_reg <= dist_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'({out_b_reg, out_a_reg, out_x_reg});
    assign m_tuser  = out_dist_reg;

    // The remainder unit only completes while the sequencer waits on it.
    a_rem_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_rsp.done |-> (run_reg && ((state_reg == ST_CLASS) || (state_reg == ST_XRED) ||
                          (state_reg == ST_EXPA) || (state_reg == ST_EXPB) ||
                          (state_reg == ST_DIST))))
        else $error("remainder unit completed outside a waiting state");

    // The multiplier only completes while the sequencer waits on it.
    a_mul_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> (run_reg && (state_reg == ST_MUL)))
        else $error("multiplier completed outside the multiply state");

    // No arithmetic unit is left running while a new request can be taken.
    a_idle_no_run: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !run_reg)
        else $error("unit still running while ready for a new transaction");

    // A result appears only after the sequencer has passed through its output state.
    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised without passing the output state");

endmodule

// ===== hw/rtl/prdw_rem.sv =====
// Bit-serial restoring remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on prdw_pkg. The caller never starts it with a zero divisor.
module prdw_rem (
    input  logic                aclk,
    input  logic                aresetn,
    input  prdw_pkg::rem_req_t  req,
    output prdw_pkg::unit_rsp_t rsp
);
    import prdw_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [REM_CNT_W-1:0] cnt_reg;
    logic [DVD_BITS-1:0]  dvd_reg;
    word_t                dvs_reg;
    word_t                rem_reg;
    word_t                rem_next;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   diff;

    // Shift the next dividend bit into the partial remainder and subtract when it fits.
    always_comb begin
        trial = {rem_reg, dvd_reg[DVD_BITS-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next = diff[WORD_BITS-1:0];
        end else begin
            rem_next = trial[WORD_BITS-1:0];
        end
    end

    // Sequencing: one step per dividend bit, then a single done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= REM_CNT_W'(DVD_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - REM_CNT_W'(1);
                if (cnt_reg == REM_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand shift register and partial remainder.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_BITS-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = rem_reg;

endmodule

// ===== hw/rtl/prdw_mul.sv =====
// Bit-serial interleaved modular multiplier: scans the multiplier from the top bit,
// doubling and conditionally adding with reduction. Depends on prdw_pkg.
module prdw_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  prdw_pkg::mul_req_t  req,
    output prdw_pkg::unit_rsp_t rsp
);
    import prdw_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic                 add_phase_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    word_t                r_reg;
    word_t                x_reg;
    word_t                y_reg;
    word_t                m_reg;
    logic                 m_zero_reg;
    word_t                r_next;
    word_t                addend;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS:0]   diff;

    // Doubling phase adds r to itself; add phase adds x when the current bit is set.
    // A zero modulus means the sum simply wraps at the word width.
    always_comb begin
        if (add_phase_reg) begin
            addend = y_reg[WORD_BITS-1] ? x_reg : '0;
        end else begin
            addend = r_reg;
        end
        sum  = {1'b0, r_reg} + {1'b0, addend};
        diff = sum - {1'b0, m_reg};
        if (!m_zero_reg && (sum >= {1'b0, m_reg})) begin
            r_next = diff[WORD_BITS-1:0];
        end else begin
            r_next = sum[WORD_BITS-1:0];
        end
    end

    // Two phases per multiplier bit, then a single done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            add_phase_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg      <= 1'b1;
                add_phase_reg <= 1'b0;
                cnt_reg       <= MUL_CNT_W'(WORD_BITS);
            end else if (busy_reg) begin
                add_phase_reg <= ~add_phase_reg;
                if (add_phase_reg) begin
                    cnt_reg <= cnt_reg - MUL_CNT_W'(1);
                    if (cnt_reg == MUL_CNT_W'(1)) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Accumulator and multiplier shift register.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            r_reg      <= '0;
            x_reg      <= req.mcand;
            y_reg      <= req.mplier;
            m_reg      <= req.modulus;
            m_zero_reg <= (req.modulus == '0);
        end else if (busy_reg) begin
            r_reg <= r_next;
            if (add_phase_reg) begin
                y_reg <= {y_reg[WORD_BITS-2:0], 1'b0};
            end
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = r_reg;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the Pollard rho walk step unit: a table of directed
// transactions, then random load-and-walk runs under several register settings.
// Depends on prdw_pkg and pollard_rho_dlog_walk_step_unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import prdw_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int CYCLE_LIMIT     = 20_000_000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int PRESSURE_AT     = 300;
    localparam int HOLD_CYCLES     = 5000;
    localparam int DRAIN_CYCLES    = 600;
    localparam int PRINT_CAP       = 40;
    localparam word_t DOUBLING     = word_t'(2);

    // One walk result: the triple held after a transaction and its marker flag.
    typedef struct packed {
        word_t x;
        word_t a;
        word_t b;
        logic  dist_flag;
    } walk_res_t;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    // A row of the directed table: either a register write or a transaction.
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic                  req;
        word_t                 x;
        word_t                 a;
        word_t                 b;
        logic                  typed;
        walk_res_t             want;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    word_t                cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;

    // Predictor copy of the registers and the walk triple.
    word_t reg_group_mod = RST_GROUP_MOD;
    word_t reg_exp_mod   = RST_EXP_MOD;
    word_t reg_generator = RST_GENERATOR;
    word_t reg_target    = RST_TARGET;
    word_t reg_dist_div  = RST_DIST_DIV;
    word_t walk_x = '0;
    word_t walk_a = '0;
    word_t walk_b = '0;

    walk_res_t expected_walk[$];
    stim_row_t directed_rows[$];

    bit calm          = 1'b0;
    bit pressure_done = 1'b0;
    int mismatches    = 0;
    int results_seen  = 0;
    int items_sent    = 0;
    int loads_done    = 0;
    int dist_seen     = 0;
    int settings_done = 0;
    int cycle_count   = 0;
    int steps_by_class[3] = '{0, 0, 0};

    always #(CLK_HALF) aclk = ~aclk;

    pollard_rho_dlog_walk_step_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Modular arithmetic; a zero modulus means plain wrap at the word width.
    function automatic word_t mod_reduce(word_t v, word_t m);
        return (m == '0) ? v : v % m;
    endfunction

    function automatic word_t mod_mul(word_t p, word_t q, word_t m);
        logic [2*WORD_BITS-1:0] prod;
        if (m == '0)
            return p * q;
        prod = {{WORD_BITS{1'b0}}, p} * {{WORD_BITS{1'b0}}, q};
        return word_t'(prod % {{WORD_BITS{1'b0}}, m});
    endfunction

    function automatic word_t mod_inc(word_t v, word_t m);
        logic [WORD_BITS:0] sum;
        if (m == '0)
            return v + word_t'(1);
        sum = {1'b0, v} + (WORD_BITS+1)'(1);
        return word_t'(sum % {1'b0, m});
    endfunction

    // Advances the predicted walk by one transaction and returns the result.
    function automatic walk_res_t predict_walk(logic req, word_t sx, word_t sa, word_t sb);
        walk_res_t  res;
        logic [1:0] cls;
        if (req == REQ_LOAD) begin
            walk_x = sx;
            walk_a = mod_reduce(sa, reg_exp_mod);
            walk_b = mod_reduce(sb, reg_exp_mod);
            loads_done++;
        end else begin
            cls = 2'(walk_x % CLASS_COUNT);
            steps_by_class[cls]++;
            case (cls)
                CLS_SQUARE: begin
                    walk_x = mod_mul(walk_x, walk_x, reg_group_mod);
                    walk_a = mod_mul(walk_a, DOUBLING, reg_exp_mod);
                    walk_b = mod_mul(walk_b, DOUBLING, reg_exp_mod);
                end
                CLS_GEN: begin
                    walk_x = mod_mul(walk_x, reg_generator, reg_group_mod);
                    walk_a = mod_inc(walk_a, reg_exp_mod);
                end
                default: begin
                    walk_x = mod_mul(walk_x, reg_target, reg_group_mod);
                    walk_b = mod_inc(walk_b, reg_exp_mod);
                end
            endcase
        end
        res.x = walk_x;
        res.a = walk_a;
        res.b = walk_b;
        if (reg_dist_div == '0)
            res.dist_flag = (walk_x == '0);
        else
            res.dist_flag = ((walk_x % reg_dist_div) == '0);
        return res;
    endfunction

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_idle();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 6);
        if (r < 97)
            return $urandom_range(10, 80);
        return $urandom_range(150, 700);
    endfunction

    task automatic report_mismatch(string what, word_t want, word_t got);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("tb: mismatch in %s at result %0d: expected %h, got %h",
                     what, results_seen, want, got);
    endtask

    // Offers one transaction, records its expectation once accepted, then may idle.
    task automatic drive_item(logic req, word_t sx, word_t sa, word_t sb,
                              logic typed, walk_res_t typed_res);
        walk_res_t pred;
        int        gap;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= TDATA_W'({sb, sa, sx});
        do @(posedge aclk); while (!s_tready);
        pred = predict_walk(req, sx, sa, sb);
        expected_walk.push_back(typed ? typed_res : pred);
        items_sent++;
        gap = pick_idle();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Lets every outstanding result arrive so the block is idle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_walk.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_GROUP_MOD: reg_group_mod = val;
            CFG_EXP_MOD:   reg_exp_mod   = val;
            CFG_GENERATOR: reg_generator = val;
            CFG_TARGET:    reg_target    = val;
            CFG_DIST_DIV:  reg_dist_div  = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, word_t val);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.x    = val;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_item(logic req, word_t sx, word_t sa, word_t sb);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.req  = req;
        r.x    = sx;
        r.a    = sa;
        r.b    = sb;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_checked(logic req, word_t sx, word_t sa, word_t sb,
                                        walk_res_t want);
        add_item(req, sx, sa, sb);
        directed_rows[$].typed = 1'b1;
        directed_rows[$].want  = want;
    endfunction

    // Directed table: reset state, small prime group, zero moduli, zero divisor,
    // the largest prime modulus, and a change of exponent modulus under held values.
    function automatic void build_directed();
        add_checked(REQ_STEP, '0, '0, '0, '{'0, '0, '0, 1'b1});
        add_checked(REQ_LOAD, '1, '1, '1, '{'1, '0, '0, 1'b0});
        add_checked(REQ_STEP, '0, '0, '0, '{'0, '0, '0, 1'b1});

        add_cfg(CFG_GROUP_MOD, 64'd23);
        add_cfg(CFG_EXP_MOD, 64'd11);
        add_cfg(CFG_GENERATOR, 64'd2);
        add_cfg(CFG_TARGET, 64'd5);
        add_cfg(CFG_DIST_DIV, 64'd4);
        add_item(REQ_LOAD, '0, '0, '0);
        add_item(REQ_LOAD, 64'd7, 64'd25, 64'd13);
        add_item(REQ_STEP, '0, '0, '0);
        add_item(REQ_STEP, '0, '0, '0);
        add_item(REQ_STEP, '0, '0, '0);
        add_item(REQ_LOAD, 64'd9, 64'd10, 64'd10);
        add_item(REQ_STEP, '0, '0, '0);
        add_item(REQ_STEP, '0, '0, '0);
        // Start element far above the group modulus, kept as given.
        add_item(REQ_LOAD, '1, '1, '0);
        add_item(REQ_STEP, '0, '0, '0);
        add_item(REQ_STEP, '0, '0, '0);

        // Both moduli zero: everything wraps at the word width.
        add_cfg(CFG_EXP_MOD, '0);
        add_cfg(CFG_GROUP_MOD, '0);
        add_item(REQ_LOAD, 64'hFFFF_FFFF_FFFF_FFFD, '1, 64'h8000_0000_0000_0005);
        add_item(REQ_STEP, '0, '0, '0);
        add_item(REQ_LOAD, 64'hFFFF_FFFF_FFFF_FFF0, 64'h8000_0000_0000_0005, '1);
        add_item(REQ_STEP, '0, '0, '0);

        // Zero divisor marks only a zero element.
        add_cfg(CFG_DIST_DIV, '0);
        add_checked(REQ_LOAD, '0, '0, '0, '{'0, '0, '0, 1'b1});
        add_item(REQ_LOAD, 64'd5, 64'd3, 64'd4);

        add_cfg(CFG_GROUP_MOD, 64'hFFFF_FFFF_FFFF_FFC5);
        add_cfg(CFG_EXP_MOD, 64'h7FFF_FFFF_FFFF_FFE2);
        add_cfg(CFG_GENERATOR, '1);
        add_cfg(CFG_TARGET, '1);
        add_cfg(CFG_DIST_DIV, '1);
        add_item(REQ_LOAD, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE);
        add_item(REQ_STEP, '0, '0, '0);
        add_item(REQ_STEP, '0, '0, '0);
        add_item(REQ_STEP, '0, '0, '0);

        // Shrinking the exponent modulus leaves a and b above it; a step reduces only the exponents its class updates.
        add_cfg(CFG_EXP_MOD, 64'd5);
        add_item(REQ_STEP, '0, '0, '0);
    endfunction

    function automatic word_t pick_element(word_t m);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return word_t'(1);
            2:       return '1;
            default: return (m == '0) ? rand_word() : rand_word() % m;
        endcase
    endfunction

    // Writes all five registers for one random phase.
    task automatic apply_setting(int phase);
        word_t gm, em, gen, tgt, dd;
        int    pick;
        pick = (phase < 7) ? phase : $urandom_range(0, 6);
        case (pick)
            0:       gm = 64'hFFFF_FFFF_FFFF_FFC5;
            1:       gm = 64'd1019;
            2:       gm = 64'd2147483647;
            3:       gm = '1;
            4:       gm = 64'd23;
            5:       gm = '0;
            default: gm = rand_word() | {1'b1, {(WORD_BITS-2){1'b0}}, 1'b1};
        endcase
        em = gm >> 1;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0:       em = '0;
                1:       em = word_t'(1);
                2:       em = rand_word();
                default: em = '1;
            endcase
        end
        gen = pick_element(gm);
        tgt = pick_element(gm);
        case ($urandom_range(0, 4))
            0:       dd = word_t'($urandom_range(1, 16));
            1:       dd = RST_DIST_DIV;
            2:       dd = rand_word();
            3:       dd = '0;
            default: dd = word_t'($urandom_range(2, 7));
        endcase
        write_reg(CFG_GROUP_MOD, gm);
        write_reg(CFG_EXP_MOD, em);
        write_reg(CFG_GENERATOR, gen);
        write_reg(CFG_TARGET, tgt);
        write_reg(CFG_DIST_DIV, dd);
        settings_done++;
    endtask

    // Random phase: mostly a load followed by a run of steps, with some stray
    // loads and lone steps mixed in.
    task automatic run_walks();
        int        sent, run_len;
        word_t     sx;
        walk_res_t none;
        none = '0;
        sent = 0;
        while (sent < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    drive_item(REQ_LOAD, rand_word(), rand_word(), rand_word(), 1'b0, none);
                else
                    drive_item(REQ_STEP, rand_word(), rand_word(), rand_word(), 1'b0, none);
                sent++;
            end else begin
                sx = (reg_group_mod == '0) ? rand_word() : rand_word() % reg_group_mod;
                drive_item(REQ_LOAD, sx, rand_word(), rand_word(), 1'b0, none);
                sent++;
                run_len = $urandom_range(4, 40);
                while (run_len > 0 && sent < ITEMS_PER_PHASE) begin
                    drive_item(REQ_STEP, rand_word(), rand_word(), rand_word(), 1'b0, none);
                    sent++;
                    run_len--;
                end
            end
        end
    endtask

    // Result side: checks each transaction against the oldest expectation and
    // drives the ready line, including one long hold-off.
    initial begin : result_sink
        int        stall_left;
        walk_res_t got, want;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.x         = m_tdata[WORD_BITS-1:0];
                got.a         = m_tdata[2*WORD_BITS-1:WORD_BITS];
                got.b         = m_tdata[3*WORD_BITS-1:2*WORD_BITS];
                got.dist_flag = m_tuser;
                results_seen++;
                if (expected_walk.size() == 0) begin
                    report_mismatch("result with nothing expected", '0, got.x);
                end else begin
                    want = expected_walk.pop_front();
                    if (got.x !== want.x)
                        report_mismatch("walk_x", want.x, got.x);
                    if (got.a !== want.a)
                        report_mismatch("walk_a", want.a, got.a);
                    if (got.b !== want.b)
                        report_mismatch("walk_b", want.b, got.b);
                    if (got.dist_flag !== want.dist_flag)
                        report_mismatch("distinguished", word_t'(want.dist_flag),
                                        word_t'(got.dist_flag));
                    if (got.dist_flag === 1'b1)
                        dist_seen++;
                end
            end
            // Long back-pressure so the block fills and stalls its input.
            if (!pressure_done && results_seen == PRESSURE_AT) begin
                pressure_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_idle();
            end
        end
    end

    // Cycle limit for a hung run.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, drain and verdict.
    initial begin : stimulus
        walk_res_t none;
        none = '0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_LOAD;
        build_directed();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(directed_rows[i].idx, directed_rows[i].x);
            end else begin
                drive_item(directed_rows[i].req, directed_rows[i].x, directed_rows[i].a,
                           directed_rows[i].b, directed_rows[i].typed,
                           directed_rows[i].typed ? directed_rows[i].want : none);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            calm = (p == 2 || p == 6);
            apply_setting(p);
            run_walks();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_walk.size() != 0)
            report_mismatch("results never delivered", word_t'(expected_walk.size()), '0);

        $display("tb: %0d transactions (%0d loads, steps by class %0d/%0d/%0d), %0d results",
                 items_sent, loads_done, steps_by_class[0], steps_by_class[1],
                 steps_by_class[2], results_seen);
        $display("tb: %0d random register settings, %0d distinguished points, %0d mismatches",
                 settings_done, dist_seen, mismatches);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
